>>> rtl/wblc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblc_pkg
// function and result codes shared by the block cache tag controller
// ----------------------------------------------------------------------------
package wblc_pkg;
  localparam logic [2:0] FN_READ = 3'd0;
  localparam logic [2:0] FN_WRITE = 3'd1;
  localparam logic [2:0] FN_DISCARD = 3'd2;
  localparam logic [2:0] FN_SYNC = 3'd3;
  localparam logic [2:0] FN_INVAL = 3'd4;

  localparam logic [2:0] K_HIT = 3'd0;
  localparam logic [2:0] K_INSTALLED = 3'd1;
  localparam logic [2:0] K_WRITEBACK = 3'd2;
  localparam logic [2:0] K_FILL = 3'd3;
  localparam logic [2:0] K_DISCARDED = 3'd4;
  localparam logic [2:0] K_NOTFOUND = 3'd5;
  localparam logic [2:0] K_DONE = 3'd6;
  localparam logic [2:0] K_ERROR = 3'd7;

  typedef logic [2:0] kind_t;
endpackage
`default_nettype wire

>>> rtl/write_back_lru_block_cache_tags_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// write_back_lru_block_cache_tags_core
// tag and lru policy controller of a fully associative write-back block cache
// ----------------------------------------------------------------------------
// One request at a time. A sequencer walks the slots one per cycle through a
// single compare unit, though a sync or invalidate walk holds while the
// result side stalls. A read, write or discard first scans all ENTRIES slots
// for a tag match while tracking the first invalid slot and the least stamp,
// then emits its result words; a read or write miss whose victim is dirty
// sends a writeback word before the final word. Sync and invalidate send
// their writeback words during the walk itself. Each result word sits in an
// output register; a new request is accepted once the last word of the
// previous one has been loaded into that register.
module write_back_lru_block_cache_tags_core #(
  parameter int ENTRIES = 32,
  parameter int DEVICES = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_func,
  input  wire  [3:0]  in_device,
  input  wire  [31:0] in_block,
  output logic        out_valid,
  input  wire         out_stall,
  output wblc_pkg::kind_t out_kind,
  output logic [3:0]  out_device,
  output logic [31:0] out_block,
  output logic [5:0]  out_slot,
  output logic        out_last
);
  import wblc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(ENTRIES - 1);

  // internal marker for a request that only answers with an error word
  localparam logic [2:0] FN_BAD = 3'd7;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  logic [ENTRIES-1:0] valid_r, dirty_r;
  logic [3:0]  dev_mem  [ENTRIES];
  logic [31:0] blk_mem  [ENTRIES];
  logic [63:0] stamp_mem[ENTRIES];
  logic [63:0] count_r;

  logic [2:0]  state_r;
  logic [2:0]  func_r;
  logic [3:0]  dev_r;
  logic [31:0] blk_r;
  logic [CW-1:0] idx_r;
  logic        hit_r, inv_r;
  logic [IW-1:0] hit_slot_r, inv_slot_r, best_r;
  logic [63:0] best_stamp_r;
  logic [IW-1:0] vic_r;

  logic [IW-1:0] idx;
  logic match;
  assign idx = idx_r[IW-1:0];
  assign match = valid_r[idx] && dev_mem[idx] == dev_r && blk_mem[idx] == blk_r;

  assign in_stall = (state_r != S_IDLE);

  logic in_err;
  assign in_err = ((in_func == FN_READ || in_func == FN_WRITE) &&
                   {1'b0, in_device} >= 5'(DEVICES)) || in_func > FN_INVAL;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // slot under the walk needs a writeback word
  logic wb_pick;
  assign wb_pick = valid_r[idx] && dirty_r[idx] &&
                   (func_r == FN_INVAL || dev_mem[idx] == dev_r);

  logic out_load;
  assign out_load = out_free && (state_r == S_EMIT || state_r == S_FINAL ||
                                 (state_r == S_WALK && wb_pick));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      dirty_r <= '0;
      count_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) stamp_mem[i] <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= in_err ? FN_BAD : in_func;
            dev_r <= in_device;
            blk_r <= in_block;
            idx_r <= '0;
            hit_r <= 1'b0;
            inv_r <= 1'b0;
            best_r <= '0;
            best_stamp_r <= stamp_mem[0];
            if (in_err) begin
              state_r <= S_FINAL;
            end else if (in_func == FN_SYNC || in_func == FN_INVAL) begin
              state_r <= S_WALK;
            end else begin
              state_r <= S_SCAN;
              if (in_func != FN_DISCARD) count_r <= count_r + 64'd1;
            end
          end
        end
        S_SCAN: begin
          if (match && !hit_r) begin
            hit_r <= 1'b1;
            hit_slot_r <= idx;
          end
          if (!valid_r[idx] && !inv_r) begin
            inv_r <= 1'b1;
            inv_slot_r <= idx;
          end
          if (stamp_mem[idx] < best_stamp_r) begin
            best_stamp_r <= stamp_mem[idx];
            best_r <= idx;
          end
          if (idx_r == LAST_IDX) state_r <= S_DECIDE;
          else idx_r <= idx_r + 1'b1;
        end
        S_DECIDE: begin
          // hit, discard or miss without a dirty victim go to the final word
          vic_r <= inv_r ? inv_slot_r : best_r;
          if (!hit_r && func_r != FN_DISCARD && !inv_r && dirty_r[best_r])
            state_r <= S_EMIT;
          else state_r <= S_FINAL;
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind <= K_WRITEBACK;
            out_device <= dev_mem[vic_r];
            out_block <= blk_mem[vic_r];
            out_slot <= 6'(vic_r);
            out_last <= 1'b0;
            dirty_r[vic_r] <= 1'b0;
            state_r <= S_FINAL;
          end
        end
        S_WALK: begin
          if (out_free) begin
            if (wb_pick) begin
              out_kind <= K_WRITEBACK;
              out_device <= dev_mem[idx];
              out_block <= blk_mem[idx];
              out_slot <= 6'(idx);
              out_last <= 1'b0;
              dirty_r[idx] <= 1'b0;
            end
            if (idx_r == LAST_IDX) state_r <= S_FINAL;
            else idx_r <= idx_r + 1'b1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_last <= 1'b1;
            state_r <= S_IDLE;
            case (func_r) inside
              FN_READ, FN_WRITE: begin
                out_device <= dev_r;
                out_block <= blk_r;
                if (hit_r) begin
                  out_kind <= K_HIT;
                  out_slot <= 6'(hit_slot_r);
                  stamp_mem[hit_slot_r] <= count_r;
                  if (func_r == FN_WRITE) dirty_r[hit_slot_r] <= 1'b1;
                end else begin
                  out_kind <= (func_r == FN_WRITE) ? K_INSTALLED : K_FILL;
                  out_slot <= 6'(vic_r);
                  valid_r[vic_r] <= 1'b1;
                  dirty_r[vic_r] <= (func_r == FN_WRITE);
                  dev_mem[vic_r] <= dev_r;
                  blk_mem[vic_r] <= blk_r;
                  stamp_mem[vic_r] <= count_r;
                end
              end
              FN_DISCARD: begin
                out_device <= dev_r;
                out_block <= blk_r;
                if (hit_r) begin
                  out_kind <= K_DISCARDED;
                  out_slot <= 6'(hit_slot_r);
                  valid_r[hit_slot_r] <= 1'b0;
                  dirty_r[hit_slot_r] <= 1'b0;
                end else begin
                  out_kind <= K_NOTFOUND;
                  out_slot <= '0;
                end
              end
              FN_SYNC: begin
                out_kind <= K_DONE;
                out_device <= dev_r;
                out_block <= '0;
                out_slot <= '0;
              end
              FN_INVAL: begin
                out_kind <= K_DONE;
                out_device <= '0;
                out_block <= '0;
                out_slot <= '0;
                valid_r <= '0;
                dirty_r <= '0;
              end
              default: begin
                out_kind <= K_ERROR;
                out_device <= dev_r;
                out_block <= blk_r;
                out_slot <= '0;
              end
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
